FILE: hdl/rlb_pkg.sv
// Shared types and constants for the RGB layer blend unit.
package rlb_pkg;

    // Width of one colour channel.
    localparam int ChanW = 8;
    // Width of a channel product plus the rounding bias (255*255 + 127 fits in 16 bits).
    localparam int ProdW = 16;
    // Width of the remainder left after the first quotient estimate.
    localparam int RemW = 9;
    // Configuration port address width and data width.
    localparam int AddrW = 3;
    localparam int DataW = 32;

    // Bias that turns a floor division by 255 into a rounded one.
    localparam logic [ProdW-1:0] RoundBias = ProdW'(127);
    // Divisor used by the reciprocal correction step.
    localparam logic [RemW-1:0]  Divisor   = RemW'(255);
    // Full scale of a channel.
    localparam logic [ChanW-1:0] FullScale = ChanW'(255);

    // Register index taken from the word address.
    localparam logic RegBlendMode = 1'b0;

    // Blend modes held in the configuration register.
    typedef enum logic [1:0] {
        MODE_MULTIPLY = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_OVERLAY  = 2'd3
    } t_blend_mode;

    // Control shared by all channel pipelines.
    typedef struct packed {
        logic        advance;
        t_blend_mode mode;
    } t_pipe_ctl;

endpackage

FILE: hdl/rlb_cfg.sv
// APB-style configuration register holding the blend mode.
module rlb_cfg
    import rlb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_blend_mode      o_mode
);

    t_blend_mode r_mode;
    t_blend_mode n_mode;
    logic        w_hit;

    // The register index is the word address; only index zero exists.
    assign w_hit = (paddr[2] == RegBlendMode);

    // Next value of the mode register on a completed write transaction.
    always_comb begin
        n_mode = r_mode;
        if (psel && penable && pwrite && pready && w_hit) begin
            n_mode = t_blend_mode'(pwdata[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MULTIPLY;
        end else begin
            r_mode <= n_mode;
        end
    end

    // Read data: the mode for index zero, zero elsewhere.
    assign prdata = w_hit ? {{(DataW-2){1'b0}}, r_mode} : '0;
    assign pready = 1'b1;
    assign o_mode = r_mode;

endmodule

FILE: hdl/rlb_chan.sv
// Four-stage blend pipeline for one colour channel.
module rlb_chan
    import rlb_pkg::*;
(
    input  logic             i_clk,
    input  t_pipe_ctl        i_ctl,
    input  logic [ChanW-1:0] i_a,
    input  logic [ChanW-1:0] i_b,
    output logic [ChanW-1:0] o_result
);

    // Stage 1 registers: multiplier operands and result handling flags.
    logic [ChanW-1:0] r_s1_p, n_s1_p;
    logic [ChanW-1:0] r_s1_m, n_s1_m;
    logic             r_s1_inv, n_s1_inv;
    logic             r_s1_byp, n_s1_byp;
    logic [ChanW-1:0] r_s1_diff, n_s1_diff;

    // Stage 2 registers: biased product.
    logic [ProdW-1:0] r_s2_y;
    logic [ProdW-1:0] n_s2_y;
    logic             r_s2_inv;
    logic             r_s2_byp;
    logic [ChanW-1:0] r_s2_diff;

    // Stage 3 registers: quotient estimate and remainder.
    logic [ChanW-1:0] r_s3_q, n_s3_q;
    logic [RemW-1:0]  r_s3_r, n_s3_r;
    logic             r_s3_inv;
    logic             r_s3_byp;
    logic [ChanW-1:0] r_s3_diff;

    // Stage 4 register: the blended channel.
    logic [ChanW-1:0] r_out, n_out;

    logic [ChanW-1:0] w_a_inv;
    logic [ChanW-1:0] w_b_inv;
    logic [ProdW-1:0] w_sum;
    logic [ProdW:0]   w_q_x255;
    logic [ChanW-1:0] w_q;

    assign w_a_inv = ~i_a;
    assign w_b_inv = ~i_b;

    // Operand selection. Screen and the upper overlay half work on the
    // inverted channels and invert the quotient again at the end.
    always_comb begin
        n_s1_p    = i_a;
        n_s1_m    = i_b;
        n_s1_inv  = 1'b0;
        n_s1_byp  = 1'b0;
        n_s1_diff = (i_a > i_b) ? (i_a - i_b) : '0;
        unique case (i_ctl.mode)
            MODE_MULTIPLY: begin
                n_s1_p = i_a;
                n_s1_m = i_b;
            end
            MODE_SUBTRACT: begin
                n_s1_p   = '0;
                n_s1_m   = '0;
                n_s1_byp = 1'b1;
            end
            MODE_SCREEN: begin
                n_s1_p   = w_a_inv;
                n_s1_m   = w_b_inv;
                n_s1_inv = 1'b1;
            end
            MODE_OVERLAY: begin
                if (!i_b[ChanW-1]) begin
                    n_s1_p = i_a;
                    n_s1_m = {i_b[ChanW-2:0], 1'b0};
                end else begin
                    n_s1_p   = w_a_inv;
                    n_s1_m   = {w_b_inv[ChanW-2:0], 1'b0};
                    n_s1_inv = 1'b1;
                end
            end
        endcase
    end

    // Product with rounding bias.
    assign n_s2_y = r_s1_p * r_s1_m + RoundBias;

    // Reciprocal estimate of y/255: at most one below the true quotient.
    assign w_sum    = r_s2_y + (r_s2_y >> ChanW);
    assign n_s3_q   = w_sum[ProdW-1:ChanW];
    assign w_q_x255 = {1'b0, n_s3_q, {ChanW{1'b0}}} - {{(ProdW+1-ChanW){1'b0}}, n_s3_q};
    assign n_s3_r   = RemW'({1'b0, r_s2_y} - w_q_x255);

    // One correction step, then the final inversion or the subtract bypass.
    assign w_q = r_s3_q + ChanW'(r_s3_r >= Divisor);
    always_comb begin
        if (r_s3_byp) begin
            n_out = r_s3_diff;
        end else if (r_s3_inv) begin
            n_out = FullScale - w_q;
        end else begin
            n_out = w_q;
        end
    end

    // All stages move together whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_s1_p    <= n_s1_p;
            r_s1_m    <= n_s1_m;
            r_s1_inv  <= n_s1_inv;
            r_s1_byp  <= n_s1_byp;
            r_s1_diff <= n_s1_diff;
            r_s2_y    <= n_s2_y;
            r_s2_inv  <= r_s1_inv;
            r_s2_byp  <= r_s1_byp;
            r_s2_diff <= r_s1_diff;
            r_s3_q    <= n_s3_q;
            r_s3_r    <= n_s3_r;
            r_s3_inv  <= r_s2_inv;
            r_s3_byp  <= r_s2_byp;
            r_s3_diff <= r_s2_diff;
            r_out     <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

FILE: hdl/rgb_layer_blend_unit.sv
// Top level of the RGB layer blend unit.
//
// The input channel takes one transaction per pixel pair: a top-layer pixel
// (i_a_*) and a bottom-layer pixel (i_b_*). The output channel gives one
// blended pixel (o_out_*) per input transaction, in order. Both channels use
// valid/ready handshakes. The blend mode is set through the APB-style port
// (register 0 at address 0) and is sampled per pixel as it enters.
//
// Each pixel passes through the four-stage pipeline: operand select,
// multiply, reciprocal estimate, correction and output register.
// Throughput is one pixel per clock when the receiver does not stall.
//
// Synchronous reset clears all valid bits and sets the mode to multiply.
// When the receiver stalls with a result waiting, the whole pipeline holds.
// Bubbles ahead of the output register are not squeezed out, so input ready
// simply follows the output register being free or being taken.
module rgb_layer_blend_unit
    import rlb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ChanW-1:0] i_a_red,
    input  logic [ChanW-1:0] i_a_green,
    input  logic [ChanW-1:0] i_a_blue,
    input  logic [ChanW-1:0] i_b_red,
    input  logic [ChanW-1:0] i_b_green,
    input  logic [ChanW-1:0] i_b_blue,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ChanW-1:0] o_out_red,
    output logic [ChanW-1:0] o_out_green,
    output logic [ChanW-1:0] o_out_blue
);

    t_blend_mode w_mode;
    t_pipe_ctl   w_ctl;
    logic        w_advance;
    logic        r_v1, r_v2, r_v3, r_vout;

    // Configuration register.
    rlb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode)
    );

    // The pipeline moves whenever the output register is empty or being taken.
    assign w_advance     = !r_vout || i_out_ready;
    assign w_ctl.advance = w_advance;
    assign w_ctl.mode    = w_mode;
    assign o_in_ready    = w_advance;

    // Valid bits travelling alongside the channel data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
        end else if (w_advance) begin
            r_v1   <= i_in_valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_vout <= r_v3;
        end
    end

    // One pipeline per colour channel.
    rlb_chan u_red (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_a      (i_a_red),
        .i_b      (i_b_red),
        .o_result (o_out_red)
    );

    rlb_chan u_green (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_a      (i_a_green),
        .i_b      (i_b_green),
        .o_result (o_out_green)
    );

    rlb_chan u_blue (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_a      (i_a_blue),
        .i_b      (i_b_blue),
        .o_result (o_out_blue)
    );

    assign o_out_valid = r_vout;

endmodule

FILE: hdl/rlb_checker.sv
// Port-level checks for the RGB layer blend unit, bound to the top level.
module rlb_checker
    import rlb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [ChanW-1:0] o_out_red,
    input logic [ChanW-1:0] o_out_green,
    input logic [ChanW-1:0] o_out_blue
);

    // No result is shown straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue))
        else $error("stalled output changed");

    // Input is taken exactly when the output register is free or draining.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output state");

    // An accepted pixel reaches the output register when the receiver does not stall in between.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            |=> o_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind rgb_layer_blend_unit rlb_checker u_rlb_checker (.*);

FILE: verif/tb_rgb_layer_blend_unit.sv
// Self-checking testbench for the RGB layer blend unit: all four modes, stalls and back-pressure.
module tb_rgb_layer_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rlb_pkg::*;

    // One RGB pixel; red sits in the top byte.
    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } t_rgb_px;

    // Top-layer and bottom-layer pixel offered together in one transaction.
    typedef struct packed {
        t_rgb_px top;
        t_rgb_px bottom;
    } t_layer_pair;

    // Register map.
    localparam int REG_BLEND_MODE = 0;
    localparam int REG_UNMAPPED   = 1;
    localparam logic [AddrW-1:0] ADDR_BLEND_MODE = AddrW'(4 * REG_BLEND_MODE);
    localparam logic [AddrW-1:0] ADDR_UNMAPPED   = AddrW'(4 * REG_UNMAPPED);

    localparam int PIPE_LATENCY  = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_PIXELS  = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int PRESSURE_PHASE = 2;
    localparam int NO_IDLE_PHASE  = 5;

    localparam t_blend_mode PHASE_MODES [PHASE_COUNT] = '{
        MODE_OVERLAY, MODE_SUBTRACT, MODE_SCREEN, MODE_MULTIPLY,
        MODE_OVERLAY, MODE_SCREEN, MODE_SUBTRACT, MODE_MULTIPLY
    };

    // Keeps its own copy of the blend mode, predicts each blended pixel and
    // compares the block's output transactions against them in order.
    class blend_scoreboard;
        t_blend_mode mode;
        t_rgb_px     expected_pixels[$];
        int unsigned fail_count;
        int unsigned pixels_seen;

        function new();
            mode        = MODE_MULTIPLY;
            fail_count  = 0;
            pixels_seen = 0;
        endfunction

        // Only the low two bits of a written value are held.
        function void set_mode(logic [DataW-1:0] value);
            mode = t_blend_mode'(value[1:0]);
        endfunction

        // Rounded division by 255 is floor((x + 127) / 255); 255 is odd, so no ties.
        function logic [ChanW-1:0] mix_channel(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
            int unsigned ua;
            int unsigned ub;
            int unsigned res;
            ua = a;
            ub = b;
            case (mode)
                MODE_MULTIPLY: begin
                    res = (ua * ub + 127) / 255;
                end
                MODE_SUBTRACT: begin
                    res = (ua > ub) ? ua - ub : 0;
                end
                MODE_SCREEN: begin
                    res = 255 - ((255 - ua) * (255 - ub) + 127) / 255;
                end
                default: begin
                    // Overlay darkens against a dark bottom layer, screens against a light one.
                    if (ub <= 127)
                        res = (2 * ua * ub + 127) / 255;
                    else
                        res = 255 - (2 * (255 - ua) * (255 - ub) + 127) / 255;
                end
            endcase
            return res[ChanW-1:0];
        endfunction

        function void note_pixel(t_layer_pair pair);
            t_rgb_px blended;
            blended.red   = mix_channel(pair.top.red,   pair.bottom.red);
            blended.green = mix_channel(pair.top.green, pair.bottom.green);
            blended.blue  = mix_channel(pair.top.blue,  pair.bottom.blue);
            expected_pixels = {expected_pixels, blended};
        endfunction

        function void flag(string what);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_pixel(t_rgb_px got);
            t_rgb_px want;
            if (expected_pixels.size() == 0) begin
                flag($sformatf("output pixel %h arrived with none expected", got));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
                flag($sformatf("pixel %0d mode %s: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                               pixels_seen, mode.name(), want.red, want.green, want.blue,
                               got.red, got.green, got.blue));
            pixels_seen++;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // Block ports; every input starts at a known value.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             psel        = 1'b0;
    logic             penable     = 1'b0;
    logic             pwrite      = 1'b0;
    logic [AddrW-1:0] paddr       = '0;
    logic [DataW-1:0] pwdata      = '0;
    logic [DataW-1:0] prdata;
    logic             pready;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic [ChanW-1:0] i_a_red     = '0;
    logic [ChanW-1:0] i_a_green   = '0;
    logic [ChanW-1:0] i_a_blue    = '0;
    logic [ChanW-1:0] i_b_red     = '0;
    logic [ChanW-1:0] i_b_green   = '0;
    logic [ChanW-1:0] i_b_blue    = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [ChanW-1:0] o_out_red;
    logic [ChanW-1:0] o_out_green;
    logic [ChanW-1:0] o_out_blue;

    // Receiver behaviour, set by the stimulus process.
    bit long_hold = 1'b0;
    bit rx_eager  = 1'b0;

    blend_scoreboard blend_sb;

    rgb_layer_blend_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_a_red     (i_a_red),
        .i_a_green   (i_a_green),
        .i_a_blue    (i_a_blue),
        .i_b_red     (i_b_red),
        .i_b_green   (i_b_green),
        .i_b_blue    (i_b_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

    // 50 MHz clock.
    always #10 i_clk = ~i_clk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Channel levels weighted towards the corners and the overlay switch point.
    function automatic logic [ChanW-1:0] pick_level();
        logic [ChanW-1:0] corners [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return ChanW'($urandom_range(0, 255));
        if (roll < 8)
            return corners[$urandom_range(0, 5)];
        return ChanW'($urandom_range(120, 135));
    endfunction

    // Random pixel pair; some bottom channels sit right next to the top one
    // so that subtract lands on both sides of its floor.
    function automatic t_layer_pair random_pair();
        t_layer_pair pair;
        logic [ChanW-1:0] a;
        logic [ChanW-1:0] offset;
        for (int c = 0; c < 3; c++) begin
            a = pick_level();
            offset = ChanW'($urandom_range(0, 2));
            pair.top[ChanW*c +: ChanW] = a;
            if ($urandom_range(0, 9) < 3)
                pair.bottom[ChanW*c +: ChanW] = $urandom_range(0, 1) ? a + offset : a - offset;
            else
                pair.bottom[ChanW*c +: ChanW] = pick_level();
        end
        return pair;
    endfunction

    // Hand-picked pairs, written as {top rgb, bottom rgb}.
    function automatic t_layer_pair directed_pair(int k);
        case (k)
            // Black on black, white on white, black on white.
            0: return {24'h00FF00, 24'h00FFFF};
            // White on black, and either side of the overlay switch point.
            1: return {24'hFF807F, 24'h007F80};
            // Operands one apart in both orders, and equal operands.
            2: return {24'h6465C8, 24'h6564C8};
            default: return {24'hAA5501, 24'h55AAFE};
        endcase
    endfunction

    task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (int'(addr >> 2) == REG_BLEND_MODE)
            blend_sb.set_mode(data);
    endtask

    // Reads the mode register back and checks it against the held copy.
    task automatic apb_check_mode();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BLEND_MODE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[1:0] !== blend_sb.mode)
            blend_sb.flag($sformatf("mode register read %h, expected %s",
                                    prdata, blend_sb.mode.name()));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one pixel pair and holds it until the block takes it.
    task automatic send_pair(input t_layer_pair pair, input int gap);
        i_in_valid <= 1'b1;
        i_a_red    <= pair.top.red;
        i_a_green  <= pair.top.green;
        i_a_blue   <= pair.top.blue;
        i_b_red    <= pair.bottom.red;
        i_b_green  <= pair.bottom.green;
        i_b_blue   <= pair.bottom.blue;
        do @(posedge i_clk); while (!o_in_ready);
        blend_sb.note_pixel(pair);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted pixel has come out and the pipeline is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (blend_sb.pending() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Sets the mode with junk in the unused upper bits, pokes the unmapped
    // register, and reads the mode back.
    task automatic set_blend_mode(input t_blend_mode mode);
        logic [DataW-1:0] junk;
        wait_idle();
        junk = $urandom() & ~DataW'(3);
        apb_write(ADDR_BLEND_MODE, junk | DataW'(mode));
        apb_write(ADDR_UNMAPPED, ~(junk | DataW'(mode)));
        apb_check_mode();
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        forever begin
            if (long_hold) begin
                stall = HOLD_CYCLES;
                long_hold = 1'b0;
            end else if (rx_eager) begin
                stall = 0;
            end else begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Every output transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            blend_sb.check_pixel('{red: o_out_red, green: o_out_green, blue: o_out_blue});
    end

    // Stimulus: directed pairs under each mode, then random phases.
    initial begin
        bit rush;
        blend_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first directed set runs on the mode left by reset.
        for (int m = 0; m < 4; m++) begin
            if (m > 0)
                set_blend_mode(t_blend_mode'(m));
            for (int k = 0; k < 4; k++)
                send_pair(directed_pair(k), pick_gap());
        end

        // Random phases; one fills the pipeline against a long receiver
        // hold-off, another runs with no idling on either side.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_blend_mode(PHASE_MODES[p]);
            rush      = (p == PRESSURE_PHASE) || (p == NO_IDLE_PHASE);
            rx_eager  = (p == NO_IDLE_PHASE);
            long_hold = (p == PRESSURE_PHASE);
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pair(random_pair(), rush ? 0 : pick_gap());
            rx_eager = 1'b0;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (blend_sb.fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
